// File: src/sha256_byte_stream_hasher_unit_defines.svh
// Assertion macros shared by the SHA-256 byte stream hasher sources.
// Define ASSERT_OFF to compile every assertion away.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// The condition holds at every clock edge outside reset.
`define SBSH_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("SBSH assertion failed: condition violated");
// The consequent holds in the same cycle as the antecedent.
`define SBSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SBSH assertion failed: implication violated");
// The consequent holds in the cycle after the antecedent.
`define SBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SBSH assertion failed: next-cycle implication violated");
`else
`define SBSH_ASSERT(label, clk, rst_n, cond)
`define SBSH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/sbsh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, round constants, initial hash values and the SHA-256 helper
// functions shared by the hasher modules.
// ---------------------------------------------------------------------------
package sbsh_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT_RD,
        ST_OUT_SHOW
    } t_state;

    // Which block a compression pass works on.
    typedef enum logic [1:0] {
        K_DATA,
        K_MARK,
        K_MARK_LEN,
        K_LEN
    } t_kind;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_ABSORB  = 2'd0;
    localparam t_cmd CMD_FINISH  = 2'd1;
    localparam t_cmd CMD_RESTART = 2'd2;

    localparam logic [7:0] PAD_MARK       = 8'h80;
    localparam logic [5:0] FILL_LONG_TAIL = 6'd56;
    localparam logic [3:0] LEN_HI_WORD    = 4'd14;
    localparam logic [3:0] LEN_LO_WORD    = 4'd15;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Control from the sequencer to the compression datapath.
    typedef struct packed {
        logic       load;
        logic [2:0] load_idx;
        logic       sched;
        logic       sched_ram;
        logic [5:0] sched_j;
        logic       round;
        logic [2:0] v_idx;
    } t_core_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // One message word of the block that a pass compresses. Marker passes
    // take stored words below the partial one, merge the pending bytes with
    // the marker byte. The last pass puts the bit count in words 14 and 15.
    function automatic logic [31:0] pad_word(
        input t_kind       kind,
        input logic [3:0]  j,
        input logic [5:0]  fill,
        input logic [23:0] acc,
        input logic [31:0] ram_word,
        input logic [63:0] bits
    );
        logic [31:0] partial;
        logic [31:0] tail;
        logic [31:0] res;
        case (fill[1:0])
            2'd0:    partial = {PAD_MARK, 24'h000000};
            2'd1:    partial = {acc[7:0], PAD_MARK, 16'h0000};
            2'd2:    partial = {acc[15:0], PAD_MARK, 8'h00};
            default: partial = {acc[23:0], PAD_MARK};
        endcase
        if (j == LEN_HI_WORD) begin
            tail = bits[63:32];
        end else if (j == LEN_LO_WORD) begin
            tail = bits[31:0];
        end else begin
            tail = 32'h0;
        end
        case (kind)
            K_DATA: begin
                res = ram_word;
            end
            K_LEN: begin
                res = tail;
            end
            K_MARK, K_MARK_LEN: begin
                if (j < fill[5:2]) begin
                    res = ram_word;
                end else if (j == fill[5:2]) begin
                    res = partial;
                end else if (kind == K_MARK_LEN) begin
                    res = tail;
                end else begin
                    res = 32'h0;
                end
            end
            default: begin
                res = ram_word;
            end
        endcase
        return res;
    endfunction

endpackage

// File: src/sbsh_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that updates
// only when a read is requested.
// ---------------------------------------------------------------------------
module sbsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sbsh_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 compression datapath
// Working variables, a 16-word message schedule window and a one-round-per-
// cycle round unit, with the schedule running one word ahead of the rounds.
// ---------------------------------------------------------------------------
module sbsh_core
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_load_word,
    input  logic [31:0] i_msg_word,
    output logic [31:0] o_v_word
);

    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] r_wk;

    logic [31:0] w_new;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        if (i_ctl.sched_ram) begin
            w_new = i_msg_word;
        end else begin
            w_new = small_sig1(r_w[14]) + r_w[9] + small_sig0(r_w[1]) + r_w[0];
        end
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + big_sig1(r_v[4]) + ch + r_wk;
        t2  = big_sig0(r_v[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sched) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= w_new;
            r_wk    <= w_new + ROUND_K[i_ctl.sched_j];
        end
        if (i_ctl.load) begin
            r_v[i_ctl.load_idx] <= i_load_word;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_v_word = r_v[i_ctl.v_idx];

endmodule

// File: src/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs message bytes, compresses full blocks, and on finish reports the
// eight digest words of the padded message without disturbing the running
// state.
// ---------------------------------------------------------------------------
// Absorb requests are taken at one per cycle, except that the byte completing
// a 64-byte block starts a compression (reading the hash memory into the
// working variables, the schedule and round steps, then read-add-write steps
// folding the result back) during which no request is taken. A finish
// request takes one such pass, or two when fewer than nine bytes of room
// remain in the partial block, and then delivers the eight digest words, each
// read from the hash memory before it is shown. The single round unit and the
// one read port of the hash memory account for these stalls. After reset and
// after a restart request the block writes the initial hash values into the
// hash memory before it takes the next request.
`include "sha256_byte_stream_hasher_unit_defines.svh"
module sha256_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    t_kind       r_kind, n_kind;
    logic [3:0]  r_cnt, n_cnt;
    logic [6:0]  r_step, n_step;
    logic [5:0]  r_fill, n_fill;
    logic [23:0] r_acc, n_acc;
    logic [63:0] r_msg, n_msg;

    logic        in_fire;
    logic        out_fire;
    logic        blk_done;
    logic        digest_done;
    logic [2:0]  cnt_m1;
    logic [5:0]  sched_j;
    logic [63:0] bits;
    logic        src_bank;
    logic        dst_bank;

    // Block buffer memory: 16 words of four packed bytes.
    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic        blk_re;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_q;

    // Hash memory: running hash words in the lower half, the working digest
    // of a finish request in the upper half.
    logic        h_we;
    logic [3:0]  h_waddr;
    logic [31:0] h_wdata;
    logic        h_re;
    logic [3:0]  h_raddr;
    logic [31:0] h_q;

    t_core_ctl   core_ctl;
    logic [31:0] msg_word;
    logic [31:0] v_word;

    sbsh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (blk_waddr),
        .i_wdata (blk_wdata),
        .i_re    (blk_re),
        .i_raddr (blk_raddr),
        .o_rdata (blk_q)
    );

    sbsh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    sbsh_core u_core (
        .i_clk       (i_clk),
        .i_ctl       (core_ctl),
        .i_load_word (h_q),
        .i_msg_word  (msg_word),
        .o_v_word    (v_word)
    );

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT_SHOW);
    assign o_digest_word = h_q;
    assign o_word_index  = r_cnt[2:0];
    assign o_last_word   = (r_cnt[2:0] == 3'd7);

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign blk_done    = in_fire && (i_command == CMD_ABSORB) && (r_fill == 6'd63);
    assign digest_done = out_fire && o_last_word;
    assign cnt_m1      = r_cnt[2:0] - 3'd1;
    assign sched_j     = 6'(r_step - 7'd1);
    assign bits        = {r_msg[60:0], 3'b000};
    assign src_bank    = (r_kind == K_LEN);
    assign dst_bank    = (r_kind != K_DATA);
    assign msg_word    = pad_word(r_kind, sched_j[3:0], r_fill, r_acc, blk_q, bits);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_fill  = r_fill;
        n_acc   = r_acc;
        n_msg   = r_msg;

        blk_we    = 1'b0;
        blk_waddr = r_fill[5:2];
        blk_wdata = {r_acc, i_data_byte};
        blk_re    = 1'b0;
        blk_raddr = r_step[3:0];

        h_we    = 1'b0;
        h_waddr = {dst_bank, cnt_m1};
        h_wdata = h_q + v_word;
        h_re    = 1'b0;
        h_raddr = {src_bank, r_cnt[2:0]};

        core_ctl           = '0;
        core_ctl.load_idx  = cnt_m1;
        core_ctl.v_idx     = cnt_m1;
        core_ctl.sched_j   = sched_j;
        core_ctl.sched_ram = (sched_j[5:4] == 2'b00);

        case (r_state)
            ST_INIT: begin
                h_we    = 1'b1;
                h_waddr = {1'b0, r_cnt[2:0]};
                h_wdata = INIT_H[r_cnt[2:0]];
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_command)
                        CMD_ABSORB: begin
                            blk_we = (r_fill[1:0] == 2'b11);
                            n_acc  = {r_acc[15:0], i_data_byte};
                            n_fill = r_fill + 6'd1;
                            n_msg  = r_msg + 64'd1;
                            if (r_fill == 6'd63) begin
                                n_kind  = K_DATA;
                                n_cnt   = '0;
                                n_state = ST_LOAD;
                            end
                        end
                        CMD_FINISH: begin
                            n_kind  = (r_fill >= FILL_LONG_TAIL) ? K_MARK : K_MARK_LEN;
                            n_cnt   = '0;
                            n_state = ST_LOAD;
                        end
                        CMD_RESTART: begin
                            n_fill  = '0;
                            n_msg   = '0;
                            n_cnt   = '0;
                            n_state = ST_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                // Each hash word read is captured into the core in the cycle after its read.
                h_re          = !r_cnt[3];
                core_ctl.load = (r_cnt != 4'd0);
                n_cnt         = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    n_cnt   = '0;
                    n_step  = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // Step s reads block word s, schedules word s-1 and runs
                // round s-2.
                blk_re         = (r_step < 7'd16);
                core_ctl.sched = (r_step != 7'd0) && (r_step <= 7'd64);
                core_ctl.round = (r_step >= 7'd2);
                n_step         = r_step + 7'd1;
                if (r_step == 7'd65) begin
                    n_cnt   = '0;
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                h_re  = !r_cnt[3];
                h_we  = (r_cnt != 4'd0);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    n_cnt = '0;
                    case (r_kind)
                        K_DATA: begin
                            n_state = ST_IDLE;
                        end
                        K_MARK: begin
                            n_kind  = K_LEN;
                            n_state = ST_LOAD;
                        end
                        default: begin
                            n_state = ST_OUT_RD;
                        end
                    endcase
                end
            end
            ST_OUT_RD: begin
                h_re    = 1'b1;
                h_raddr = {1'b1, r_cnt[2:0]};
                n_state = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                if (out_fire) begin
                    if (r_cnt[2:0] == 3'd7) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 4'd1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_kind  <= K_DATA;
            r_cnt   <= '0;
            r_step  <= '0;
            r_fill  <= '0;
            r_msg   <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
        end
        r_acc <= n_acc;
    end

    `SBSH_ASSERT(a_in_out_exclusive, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `SBSH_ASSERT_IMPL(a_step_range, i_clk, i_rst_n, r_state == ST_ROUND, r_step <= 7'd65)
    `SBSH_ASSERT_NEXT(a_block_full, i_clk, i_rst_n, blk_done, r_state == ST_LOAD && r_kind == K_DATA)
    `SBSH_ASSERT_NEXT(a_last_word_done, i_clk, i_rst_n, digest_done, o_in_ready && $stable(r_fill))

endmodule

// File: tb/sha256_byte_stream_hasher_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Sends absorb, finish, restart and unused requests under random idling on
// both channels, save for a steady stretch. Every digest word is checked
// against a local SHA-256 predictor or known digests in the directed table.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_test;
    import sbsh_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;
    localparam int   RAND_ITEMS = 200;
    localparam int   DIR_COUNT  = 21;
    localparam int   IDLE_PCT   = 37;

    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [255:0] HASH_START =
        256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        t_cmd         cmd;
        logic [7:0]   data;
        logic         pinned;
        logic [255:0] digest;
    } t_dir_row;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_beat;

    // Digests are given only where the message is a well-known test vector.
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        '{CMD_FINISH,  8'h00, 1'b1, DIGEST_EMPTY},
        '{CMD_ABSORB,  8'h61, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'h62, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'h63, 1'b0, 256'h0},
        '{CMD_FINISH,  8'hff, 1'b1, DIGEST_ABC},
        '{CMD_FINISH,  8'h00, 1'b1, DIGEST_ABC},
        '{CMD_UNUSED,  8'hff, 1'b0, 256'h0},
        '{CMD_FINISH,  8'h55, 1'b1, DIGEST_ABC},
        '{CMD_ABSORB,  8'h00, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'hff, 1'b0, 256'h0},
        '{CMD_FINISH,  8'h00, 1'b0, 256'h0},
        '{CMD_RESTART, 8'hff, 1'b0, 256'h0},
        '{CMD_FINISH,  8'h00, 1'b1, DIGEST_EMPTY},
        '{CMD_UNUSED,  8'h00, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'h80, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'h7f, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'h01, 1'b0, 256'h0},
        '{CMD_ABSORB,  8'hfe, 1'b0, 256'h0},
        '{CMD_FINISH,  8'haa, 1'b0, 256'h0},
        '{CMD_RESTART, 8'h00, 1'b0, 256'h0},
        '{CMD_FINISH,  8'h3c, 1'b1, DIGEST_EMPTY}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_cmd        in_cmd;
    logic [7:0]  in_data;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Running message state of the predictor.
    logic [255:0] hash_st;
    logic [511:0] blk_buf;
    logic [5:0]   fill_cnt;
    logic [63:0]  msg_len;

    t_digest_beat pending_words [$];
    int  reqs_sent     = 0;
    int  finishes_sent = 0;
    int  words_checked = 0;
    int  mismatch_cnt  = 0;
    bit  steady        = 1'b0;

    sha256_byte_stream_hasher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (in_cmd),
        .i_data_byte   (in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Hash words are packed word 0 first; block bytes are packed byte 0 first.
    function automatic logic [255:0] compress_block(input logic [255:0] h_in,
                                                    input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int i;
        for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 64; i++) begin
            w[i] = w[i - 16] + w[i - 7]
                 + (ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3))
                 + (ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10));
        end
        {a, b, c, d, e, f, g, h} = h_in;
        for (i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + RK[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        return {h_in[255:224] + a, h_in[223:192] + b, h_in[191:160] + c,
                h_in[159:128] + d, h_in[127:96] + e, h_in[95:64] + f,
                h_in[63:32] + g, h_in[31:0] + h};
    endfunction

    // Pads a copy of the running state; the state itself is left alone.
    function automatic logic [255:0] padded_digest();
        logic [511:0] wb;
        logic [255:0] h;
        int pos;
        h = hash_st;
        wb = blk_buf;
        pos = fill_cnt;
        wb[511 - 8 * pos -: 8] = 8'h80;
        pos++;
        if (pos > 56) begin
            for (; pos < 64; pos++) wb[511 - 8 * pos -: 8] = 8'h00;
            h = compress_block(h, wb);
            pos = 0;
        end
        for (; pos < 56; pos++) wb[511 - 8 * pos -: 8] = 8'h00;
        wb[63:0] = msg_len << 3;
        return compress_block(h, wb);
    endfunction

    task automatic send_req(input t_cmd c, input logic [7:0] b,
                            input logic pinned, input logic [255:0] fixed_digest);
        logic [255:0] dig;
        t_digest_beat beat;
        @(negedge i_clk);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_cmd   <= c;
        in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (c)
            CMD_ABSORB: begin
                blk_buf[511 - 8 * fill_cnt -: 8] = b;
                msg_len++;
                if (fill_cnt == 6'd63) begin
                    hash_st = compress_block(hash_st, blk_buf);
                    fill_cnt = 6'd0;
                end else begin
                    fill_cnt++;
                end
            end
            CMD_RESTART: begin
                hash_st  = HASH_START;
                fill_cnt = 6'd0;
                msg_len  = 64'd0;
            end
            CMD_FINISH: begin
                dig = pinned ? fixed_digest : padded_digest();
                for (int i = 0; i < 8; i++) begin
                    beat.word = dig[255 - 32 * i -: 32];
                    beat.idx  = 3'(i);
                    beat.last = (i == 7);
                    pending_words.push_back(beat);
                end
                finishes_sent++;
            end
            default: ;
        endcase
        reqs_sent++;
    endtask

    always @(negedge i_clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                         o_digest_word, o_word_index, o_last_word);
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (o_digest_word !== want.word) begin
                    mismatch_cnt++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.word, o_digest_word);
                end
                if (o_word_index !== want.idx) begin
                    mismatch_cnt++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.idx, o_word_index);
                end
                if (o_last_word !== want.last) begin
                    mismatch_cnt++;
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             want.last, o_last_word);
                end
            end
        end
    end

    initial begin
        int len;
        int msg_no;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_cmd   = CMD_ABSORB;
        in_data  = 8'h00;
        hash_st  = HASH_START;
        blk_buf  = '0;
        fill_cnt = 6'd0;
        msg_len  = 64'd0;
        msg_no   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_COUNT; r++) begin
            send_req(DIR_ROWS[r].cmd, DIR_ROWS[r].data, DIR_ROWS[r].pinned,
                     DIR_ROWS[r].digest);
        end

        // Random messages. The first three put the pad marker just before the
        // length field, at it (an extra padding block) and after a full block.
        while (reqs_sent < DIR_COUNT + RAND_ITEMS) begin
            msg_no++;
            case (msg_no)
                1: len = 55;
                2: len = 56;
                3: len = 64;
                default: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 72)
                                                      : $urandom_range(0, 30);
                end
            endcase
            send_req(CMD_RESTART, 8'($urandom_range(0, 255)), 1'b0, '0);
            for (int k = 0; k < len; k++) begin
                steady = (reqs_sent >= DIR_COUNT + 90) && (reqs_sent < DIR_COUNT + 150);
                if ($urandom_range(0, 9) == 0) begin
                    send_req(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
                send_req(CMD_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
                if ($urandom_range(0, 7) == 0) begin
                    send_req(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
            end
            send_req(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        steady = 1'b0;
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Run covered %0d requests, %0d of them digest requests, %0d words checked.",
                 reqs_sent, finishes_sent, words_checked);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches found.", mismatch_cnt);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Timeout with %0d digest words still outstanding.", pending_words.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
